[src/sbi_pkg.sv]
// Shared types and constants for the sorted breakpoint interpolator.
`timescale 1ns / 1ps
package sbi_pkg;
    localparam logic [1:0] REQ_ADD    = 2'd0;
    localparam logic [1:0] REQ_QUERY  = 2'd1;
    localparam logic [1:0] REQ_RESET  = 2'd2;
    localparam logic [1:0] REQ_LATEST = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DUP  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Control between the sequencer and the divider.
    typedef struct packed {
        logic start;
        logic busy;
        logic done;
    } div_ctl_t;
endpackage

[src/sbi_divider.sv]
// Restoring serial divider: one quotient bit per cycle, floor(num / den).
`timescale 1ns / 1ps
module sbi_divider #(
    parameter int NUM_W = 96,
    parameter int DEN_W = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output sbi_pkg::div_ctl_t ctl,
    output logic [NUM_W-1:0] quo
);
    localparam int CW = $clog2(NUM_W + 1);

    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DEN_W:0]   rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;

    // One restoring step: shift in the next numerator bit and try a subtract.
    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        shifted   = {rem_reg[DEN_W-1:0], quo_reg[NUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(NUM_W);
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, den_reg})
            begin
                rem_next = shifted - {1'b0, den_reg};
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign ctl.start = start;
    assign ctl.busy  = busy_reg;
    assign ctl.done  = done_reg;
    assign quo       = quo_reg;
endmodule

[src/sorted_breakpoint_interpolator_unit.sv]
// Top level of the sorted breakpoint interpolator with its request sequencer.
`timescale 1ns / 1ps
// One item at a time. The table lives in three single-port memories walked by
// a sequencer. After reset an init state clears the first entry, during which
// no item is taken. An add scans the table one entry at a time (the read is
// registered) up to the insertion point, then shifts the upper entries up
// one at a time, each with a read and a write. A query scans for the
// bracketing pair, forms the product in four 24x24 partial products and runs
// a serial divider over the 2*VALUE_WIDTH-bit product; a query time before the
// first entry or at or past the last returns that end entry's value. The
// result sits in an output register; the next item is taken once it has been
// handed over.
module sorted_breakpoint_interpolator_unit #(
    parameter int TABLE_DEPTH = 64,
    parameter int VALUE_WIDTH = 48
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // tdata: point_time, point_nominal, point_absolute (lowest bits first)
    input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
    // tuser: req_type
    input  logic [1:0] s_tuser,
    output logic m_tvalid,
    input  logic m_tready,
    // tdata: value_absolute, latest_time, latest_nominal (lowest bits first)
    output logic [((3*VALUE_WIDTH+7)/8)*8-1:0] m_tdata,
    // tuser: status
    output logic [1:0] m_tuser
);
    localparam int W   = VALUE_WIDTH;
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int NW  = $clog2(TABLE_DEPTH + 1);
    localparam int DW  = ((3*W+7)/8)*8;
    localparam int HW  = (W + 1) / 2;
    localparam int PW  = 2 * W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SRD   = 4'd1;
    localparam logic [3:0] S_SCMP  = 4'd2;
    localparam logic [3:0] S_SHRD  = 4'd3;
    localparam logic [3:0] S_SHWR  = 4'd4;
    localparam logic [3:0] S_INS   = 4'd5;
    localparam logic [3:0] S_LRD   = 4'd6;
    localparam logic [3:0] S_LGET  = 4'd7;
    localparam logic [3:0] S_QL    = 4'd8;
    localparam logic [3:0] S_QLG   = 4'd9;
    localparam logic [3:0] S_MUL   = 4'd10;
    localparam logic [3:0] S_DIV   = 4'd11;
    localparam logic [3:0] S_DWAIT = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;
    localparam logic [3:0] S_INIT  = 4'd14;

    // Table memories.
    logic [W-1:0] t_mem [TABLE_DEPTH];
    logic [W-1:0] n_mem [TABLE_DEPTH];
    logic [W-1:0] a_mem [TABLE_DEPTH];
    logic [W-1:0] t_rd, n_rd, a_rd;
    logic [AW-1:0] addr;
    logic          we;
    logic [W-1:0]  wt, wn, wa;

    logic [3:0]    state_reg, state_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] pos_reg, pos_next;
    logic [1:0]    req_reg, req_next;
    logic [W-1:0]  pt_reg, pt_next, pn_reg, pn_next, pa_reg, pa_next;
    logic [W-1:0]  lt_reg, lt_next, la_reg, la_next;
    logic [W-1:0]  st_reg, st_next, sa_reg, sa_next;
    logic [W-1:0]  dx_reg, dx_next, x_reg, x_next, mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [1:0]    mstep_reg, mstep_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [W-1:0]  val_reg, val_next, ot_reg, ot_next, on_reg, on_next;
    logic [1:0]    stat_reg, stat_next;
    logic          ov_reg, ov_next;
    logic          dstart;
    sbi_pkg::div_ctl_t dctl;
    logic [PW-1:0] dquo;

    logic [W-1:0]  in_t, in_n, in_a;
    logic [HW-1:0] ma, mb;
    logic [2*HW-1:0] pp;
    logic signed [W:0] st_s, pt_s;

    assign in_t = s_tdata[W-1:0];
    assign in_n = s_tdata[2*W-1:W];
    assign in_a = s_tdata[3*W-1:2*W];

    // Memory port: one optional write and one registered read per cycle, at one shared address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            t_mem[addr] <= wt;
            n_mem[addr] <= wn;
            a_mem[addr] <= wa;
        end
        t_rd <= t_mem[addr];
        n_rd <= n_mem[addr];
        a_rd <= a_mem[addr];
    end

    // Shared partial-product multiplier.
    always_comb
    begin
        ma = mstep_reg[0] ? HW'(mag_reg >> HW) : mag_reg[HW-1:0];
        mb = mstep_reg[1] ? HW'(x_reg >> HW) : x_reg[HW-1:0];
        pp = ma * mb;
    end

    assign st_s = {st_reg[W-1], st_reg};
    assign pt_s = {pt_reg[W-1], pt_reg};

    sbi_divider #(.NUM_W(PW), .DEN_W(W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dstart),
        .num   (prod_reg),
        .den   (dx_reg),
        .ctl   (dctl),
        .quo   (dquo)
    );

    // Request sequencer.
    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg; pos_next = pos_reg; req_next = req_reg;
        pt_next = pt_reg; pn_next = pn_reg; pa_next = pa_reg;
        lt_next = lt_reg; la_next = la_reg;
        st_next = st_reg; sa_next = sa_reg;
        dx_next = dx_reg; x_next = x_reg; mag_next = mag_reg; neg_next = neg_reg;
        mstep_next = mstep_reg; prod_next = prod_reg;
        val_next = val_reg; ot_next = ot_reg; on_next = on_reg;
        stat_next = stat_reg; ov_next = ov_reg;
        addr = '0; we = 1'b0; wt = pt_reg; wn = pn_reg; wa = pa_reg;
        dstart = 1'b0;
        s_tready = (state_reg == S_IDLE) && !ov_reg;
        if (ov_reg && m_tready)
        begin
            ov_next = 1'b0;
        end
        unique case (state_reg)
            // The first entry reads as zero after reset.
            S_INIT:
            begin
                addr = '0; we = 1'b1;
                wt = '0; wn = '0; wa = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    req_next = s_tuser; pt_next = in_t; pn_next = in_n;
                    pa_next = in_a; pos_next = '0; stat_next = sbi_pkg::ST_OK;
                    unique case (s_tuser)
                        sbi_pkg::REQ_RESET:
                        begin
                            addr = '0; we = 1'b1;
                            wt = in_t; wn = in_n; wa = in_a;
                            cnt_next = NW'(1);
                            state_next = S_LRD;
                        end
                        sbi_pkg::REQ_ADD:
                        begin
                            state_next = S_SRD;
                        end
                        sbi_pkg::REQ_QUERY:
                        begin
                            state_next = S_SRD;
                        end
                        default:
                        begin
                            state_next = S_LRD;
                        end
                    endcase
                end
            end
            // Scan: read entry pos.
            S_SRD:
            begin
                addr = AW'(pos_reg);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                st_next = t_rd; sa_next = a_rd;
                if (req_reg == sbi_pkg::REQ_ADD)
                begin
                    if ($signed(t_rd) == $signed(pt_reg))
                    begin
                        stat_next = sbi_pkg::ST_DUP; state_next = S_LRD;
                    end
                    else if ($signed(t_rd) > $signed(pt_reg))
                    begin
                        if (cnt_reg >= NW'(TABLE_DEPTH))
                        begin
                            stat_next = sbi_pkg::ST_FULL; state_next = S_LRD;
                        end
                        else
                        begin
                            pos_next = cnt_reg; state_next = S_SHRD;
                            lt_next = W'(pos_reg);
                        end
                    end
                    else if (pos_reg + 1'b1 == cnt_reg)
                    begin
                        if (cnt_reg >= NW'(TABLE_DEPTH))
                        begin
                            stat_next = sbi_pkg::ST_FULL; state_next = S_LRD;
                        end
                        else
                        begin
                            pos_next = cnt_reg; lt_next = W'(cnt_reg);
                            state_next = S_INS;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1; state_next = S_SRD;
                    end
                end
                else
                begin
                    // Query: find first entry with time above the query.
                    if ($signed(t_rd) > $signed(pt_reg) || pos_reg + 1'b1 == cnt_reg)
                    begin
                        if (pos_reg == '0 || $signed(t_rd) <= $signed(pt_reg))
                        begin
                            val_next = a_rd; state_next = S_LRD;
                        end
                        else
                        begin
                            pos_next = pos_reg - 1'b1; state_next = S_QL;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 1'b1; state_next = S_SRD;
                    end
                end
            end
            // Shift the entries at and above the insertion point up by one.
            S_SHRD:
            begin
                if (pos_reg == NW'(lt_reg))
                begin
                    state_next = S_INS;
                end
                else
                begin
                    addr = AW'(pos_reg - 1'b1); state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                addr = AW'(pos_reg); we = 1'b1;
                wt = t_rd; wn = n_rd; wa = a_rd;
                pos_next = pos_reg - 1'b1; state_next = S_SHRD;
            end
            S_INS:
            begin
                addr = AW'(lt_reg); we = 1'b1;
                cnt_next = cnt_reg + 1'b1; state_next = S_LRD;
            end
            // Read the last (highest-time) point for the result.
            S_LRD:
            begin
                addr = AW'(cnt_reg - 1'b1); state_next = S_LGET;
            end
            S_LGET:
            begin
                ot_next = t_rd; on_next = n_rd;
                if (req_reg != sbi_pkg::REQ_QUERY)
                begin
                    val_next = a_rd;
                end
                state_next = S_OUT;
            end
            S_QL:
            begin
                addr = AW'(pos_reg); state_next = S_QLG;
            end
            S_QLG:
            begin
                la_next = a_rd;
                dx_next = W'(st_s - {t_rd[W-1], t_rd});
                x_next  = W'(pt_s - {t_rd[W-1], t_rd});
                if ($signed(sa_reg) >= $signed(a_rd))
                begin
                    neg_next = 1'b0; mag_next = sa_reg - a_rd;
                end
                else
                begin
                    neg_next = 1'b1; mag_next = a_rd - sa_reg;
                end
                mstep_next = 2'd0; prod_next = '0; state_next = S_MUL;
            end
            S_MUL:
            begin
                prod_next = prod_reg
                    + (PW'(pp) << (HW * (32'(mstep_reg[0]) + 32'(mstep_reg[1]))));
                mstep_next = mstep_reg + 1'b1;
                if (mstep_reg == 2'd3)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                dstart = 1'b1; state_next = S_DWAIT;
            end
            S_DWAIT:
            begin
                if (dctl.done)
                begin
                    val_next = neg_reg ? la_reg - dquo[W-1:0] : la_reg + dquo[W-1:0];
                    state_next = S_LRD;
                end
            end
            S_OUT:
            begin
                if (!ov_reg || m_tready)
                begin
                    ov_next = 1'b1; state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= NW'(1);
            ov_reg    <= 1'b0;
            mstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            mstep_reg <= mstep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next; req_reg <= req_next;
        pt_reg <= pt_next; pn_reg <= pn_next; pa_reg <= pa_next;
        lt_reg <= lt_next; la_reg <= la_next;
        st_reg <= st_next; sa_reg <= sa_next;
        dx_reg <= dx_next; x_reg <= x_next; mag_reg <= mag_next; neg_reg <= neg_next;
        prod_reg <= prod_next;
        val_reg <= val_next; ot_reg <= ot_next; on_reg <= on_next;
        stat_reg <= stat_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = DW'({on_reg, ot_reg, val_reg});
    assign m_tuser  = stat_reg;
endmodule

[src/sbi_checker.sv]
// Port-level checks for the sorted breakpoint interpolator, bound to the top level.
`timescale 1ns / 1ps
module sbi_checker (
    input logic clk,
    input logic rst_n,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [1:0] m_tuser
);
    // Only one item is in flight: no new item while a result waits.
    a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input accepted while result pending");

    // An accepted item is not followed at once by another acceptance.
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready) else $error("back to back accept");

    // Status codes stay in range.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3)) else $error("bad status");

    // A waiting result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
endmodule

bind sorted_breakpoint_interpolator_unit sbi_checker u_sbi_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tuser(m_tuser)
);

[test/tb_sorted_breakpoint_interpolator_unit.sv]
// Self-checking testbench for the sorted breakpoint interpolator unit.
`timescale 1ns / 1ps
module tb_sorted_breakpoint_interpolator_unit;

    localparam int DEPTH = 64;
    localparam int VW = 48;
    localparam int DW = ((3*VW+7)/8)*8;
    localparam int ITEM_TARGET = 650;

    typedef logic signed [VW-1:0] val_t;

    typedef struct {
        logic       pause;
        logic [1:0] req;
        val_t       t;
        val_t       nom;
        val_t       ab;
    } request_t;

    typedef struct {
        logic [1:0] status;
        val_t       value;
        val_t       last_t;
        val_t       last_nom;
    } response_t;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [DW-1:0] m_tdata;
    logic [1:0]    m_tuser;

    sorted_breakpoint_interpolator_unit #(
        .TABLE_DEPTH(DEPTH),
        .VALUE_WIDTH(VW)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    // Shadow copy of the breakpoint table.
    val_t bp_time [DEPTH];
    val_t bp_nom [DEPTH];
    val_t bp_abs [DEPTH];
    int   bp_count = 1;

    request_t  pending_requests[$];
    response_t expected_responses[$];

    int  mismatches = 0;
    int  responses_seen = 0;
    int  requests_sent = 0;
    int  full_drops = 0;
    int  dup_hits = 0;
    bit  burst_mode = 0;
    bit  stim_done = 0;

    always #1 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(15, 60);
    endfunction

    // Either a full-range value or a small time on a coarse grid.
    function automatic val_t pick_value(bit coarse);
        logic [63:0] w;
        w = {$urandom, $urandom};
        if (coarse)
            return val_t'($urandom_range(0, 40)) <<< 16;
        return val_t'(w[VW-1:0]);
    endfunction

    // Interpolated absolute value at time t between neighbouring breakpoints.
    function automatic val_t interpolate_at(val_t t);
        logic signed [2*VW+3:0] rise, run, span, quot;
        int r;
        if (t <= bp_time[0])
            return bp_abs[0];
        if (t >= bp_time[bp_count-1])
            return bp_abs[bp_count-1];
        r = 1;
        while (r < bp_count - 1 && bp_time[r] <= t)
            r++;
        rise = bp_abs[r];
        rise = rise - bp_abs[r-1];
        run  = t;
        run  = run - bp_time[r-1];
        span = bp_time[r];
        span = span - bp_time[r-1];
        quot = (rise * run) / span;
        return val_t'(bp_abs[r-1] + quot[VW-1:0]);
    endfunction

    // Applies one request to the shadow table and returns its response.
    function automatic response_t apply_request(request_t rq);
        response_t rs;
        int pos;
        rs.status = sbi_pkg::ST_OK;
        if (rq.req == sbi_pkg::REQ_ADD) begin
            pos = 0;
            while (pos < bp_count && bp_time[pos] < rq.t)
                pos++;
            if (pos < bp_count && bp_time[pos] == rq.t) begin
                rs.status = sbi_pkg::ST_DUP;
            end
            else if (bp_count >= DEPTH) begin
                rs.status = sbi_pkg::ST_FULL;
            end
            else begin
                for (int i = bp_count; i > pos; i--) begin
                    bp_time[i] = bp_time[i-1];
                    bp_nom[i]  = bp_nom[i-1];
                    bp_abs[i]  = bp_abs[i-1];
                end
                bp_time[pos] = rq.t;
                bp_nom[pos]  = rq.nom;
                bp_abs[pos]  = rq.ab;
                bp_count++;
            end
        end
        else if (rq.req == sbi_pkg::REQ_RESET) begin
            bp_time[0] = rq.t;
            bp_nom[0]  = rq.nom;
            bp_abs[0]  = rq.ab;
            bp_count   = 1;
        end
        rs.value    = (rq.req == sbi_pkg::REQ_QUERY) ? interpolate_at(rq.t)
                                                     : bp_abs[bp_count-1];
        rs.last_t   = bp_time[bp_count-1];
        rs.last_nom = bp_nom[bp_count-1];
        return rs;
    endfunction

    task automatic queue_request(logic [1:0] req, val_t t, val_t nom, val_t ab);
        request_t rq;
        rq.pause = 0;
        rq.req   = req;
        rq.t     = t;
        rq.nom   = nom;
        rq.ab    = ab;
        pending_requests.push_back(rq);
    endtask

    task automatic queue_pause();
        request_t rq;
        rq.pause = 1;
        rq.req   = sbi_pkg::REQ_LATEST;
        rq.t     = '0;
        rq.nom   = '0;
        rq.ab    = '0;
        pending_requests.push_back(rq);
    endtask

    // Sender: one item in flight on the input, with gaps and pauses.
    int  send_gap = 0;
    bit  draining = 0;
    always @(posedge clk or negedge rst_n)
    begin
        request_t rq;
        response_t rs;
        logic next_valid;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else if (!(s_tvalid && !s_tready)) begin
            next_valid = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
            end
            else if (draining) begin
                if (expected_responses.size() == 0)
                    draining = 0;
            end
            else if (pending_requests.size() > 0) begin
                rq = pending_requests.pop_front();
                if (rq.pause) begin
                    draining = 1;
                end
                else begin
                    rs = apply_request(rq);
                    if (rs.status == sbi_pkg::ST_FULL)
                        full_drops++;
                    if (rs.status == sbi_pkg::ST_DUP)
                        dup_hits++;
                    expected_responses.push_back(rs);
                    s_tdata    <= DW'({rq.ab, rq.nom, rq.t});
                    s_tuser    <= rq.req;
                    next_valid = 1'b1;
                    requests_sent++;
                    send_gap = pick_gap();
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // Receiver: checks each result item and drives backpressure.
    int  stall_left = 0;
    bit  long_hold_done = 0;
    always @(posedge clk or negedge rst_n)
    begin
        response_t rs;
        val_t got_value, got_t, got_nom;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                got_value = m_tdata[VW-1:0];
                got_t     = m_tdata[2*VW-1:VW];
                got_nom   = m_tdata[3*VW-1:2*VW];
                responses_seen++;
                if (expected_responses.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result item: status %0d value %0d",
                                 m_tuser, got_value);
                end
                else begin
                    rs = expected_responses.pop_front();
                    if (rs.status !== m_tuser || rs.value !== got_value ||
                        rs.last_t !== got_t || rs.last_nom !== got_nom) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"Result %0d differs: status %0d/%0d value %0d/%0d ",
                                      "latest time %0d/%0d latest nominal %0d/%0d ",
                                      "(expected/actual)"},
                                     responses_seen, rs.status, m_tuser, rs.value,
                                     got_value, rs.last_t, got_t, rs.last_nom, got_nom);
                    end
                end
            end
            // One long hold-off while the sender keeps offering items.
            if (!long_hold_done && responses_seen >= 120) begin
                long_hold_done = 1;
                stall_left = 600;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else begin
                m_tready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    // Stimulus generation and end of run.
    initial
    begin
        int n_adds, items;
        bit coarse;
        val_t vmax, vmin;
        vmax = {1'b0, {(VW-1){1'b1}}};
        vmin = {1'b1, {(VW-1){1'b0}}};
        clk      = 1'b0;
        rst_n    = 1'b0;

        // Directed: extremes, every request kind and the corner cases.
        queue_request(sbi_pkg::REQ_LATEST, '0, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, 48'sd12345, '0, '0);
        queue_request(sbi_pkg::REQ_ADD, '0, vmax, vmin);
        queue_request(sbi_pkg::REQ_ADD, vmax, vmax, vmax);
        queue_request(sbi_pkg::REQ_ADD, vmin, vmin, vmin);
        queue_request(sbi_pkg::REQ_QUERY, vmin, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, vmax, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, '0, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, vmin + 1, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, vmax - 1, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, -48'sd7, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, 48'sd7, '0, '0);
        queue_request(sbi_pkg::REQ_RESET, 48'sd327680, -48'sd65536, 48'sd1000000);
        queue_request(sbi_pkg::REQ_QUERY, -48'sd6553600, '0, '0);
        queue_request(sbi_pkg::REQ_ADD, 48'sd655360, 48'sd3, -48'sd500000);
        queue_request(sbi_pkg::REQ_QUERY, 48'sd458752, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, 48'sd655360, '0, '0);
        queue_request(sbi_pkg::REQ_QUERY, 48'sd6553600, '0, '0);
        queue_request(sbi_pkg::REQ_ADD, 48'sd655360, '0, '0);
        queue_request(sbi_pkg::REQ_ADD, 48'sd393216, 48'sd1, 48'sd3);
        queue_request(sbi_pkg::REQ_QUERY, 48'sd350000, '0, '0);
        queue_request(sbi_pkg::REQ_LATEST, '0, '0, '0);
        queue_pause();
        items = 22;

        // Random: in most rounds a reset to a point, then adds with queries in between.
        while (items < ITEM_TARGET) begin
            burst_mode = ($urandom_range(0, 5) == 0);
            coarse = $urandom_range(0, 1);
            n_adds = ($urandom_range(0, 7) == 0) ? 70 : $urandom_range(2, 12);
            if ($urandom_range(0, 3) != 0) begin
                queue_request(sbi_pkg::REQ_RESET, pick_value(coarse), pick_value(0),
                              pick_value(0));
                items++;
            end
            for (int k = 0; k < n_adds; k++) begin
                queue_request(sbi_pkg::REQ_ADD, pick_value(coarse), pick_value(0),
                              pick_value(0));
                items++;
                if ($urandom_range(0, 2) == 0 || n_adds < 20) begin
                    queue_request(sbi_pkg::REQ_QUERY, pick_value(coarse), pick_value(0),
                                  pick_value(0));
                    items++;
                end
                if ($urandom_range(0, 9) == 0) begin
                    queue_request(sbi_pkg::REQ_LATEST, pick_value(0), pick_value(0),
                                  pick_value(0));
                    items++;
                end
            end
            for (int k = 0; k < 3; k++) begin
                queue_request(sbi_pkg::REQ_QUERY, pick_value(coarse), pick_value(0),
                              pick_value(0));
                items++;
            end
            if ($urandom_range(0, 4) == 0)
                queue_pause();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all items to go out and every result to come back.
        wait (pending_requests.size() == 0 && !draining && !s_tvalid &&
              expected_responses.size() == 0);
        repeat (1000) @(posedge clk);

        $display("Sent %0d requests and checked %0d results, with %0d full-table drops",
                 requests_sent, responses_seen, full_drops);
        $display("and %0d duplicate times, under random stalls on both sides.", dup_hits);
        if (mismatches == 0 && expected_responses.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #6000000;
        $display("Timeout with %0d results outstanding.", expected_responses.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        m_tready = 1'b0;
    end

endmodule

[sim.f]
src/sbi_pkg.sv
src/sbi_divider.sv
src/sorted_breakpoint_interpolator_unit.sv
src/sbi_checker.sv
test/tb_sorted_breakpoint_interpolator_unit.sv
